@@ hdl/brb_pkg.sv @@
// ----------------------------------------------------------------------------
// brb_pkg
// Shared constants and types for the broadcast ring buffer: default sizes,
// operation codes, control states and the result status flags.
// ----------------------------------------------------------------------------
package brb_pkg;

    // default sizes for the top-level parameters
    localparam int RING_DEPTH_DEF  = 1024;
    localparam int MAX_READERS_DEF = 8;
    localparam int DATA_WIDTH_DEF  = 32;

    // fixed field widths
    localparam int RID_W = 3;
    localparam int CFG_W = 4;

    // reset value of the active reader count
    localparam logic [CFG_W-1:0] ACTIVE_READERS_RST = 4'd2;

    // operation codes carried on the input tuser
    localparam logic OP_PUBLISH = 1'b0;
    localparam logic OP_CONSUME = 1'b1;

    // control states
    typedef enum logic [0:0] {
        ST_IDLE,
        ST_EXEC
    } state_t;

    // result flags, accepted in the lowest bit
    typedef struct packed {
        logic slot_released;
        logic empty_res;
        logic full_res;
        logic accepted;
    } status_t;

endpackage

@@ hdl/brb_slot_mem.sv @@
// ----------------------------------------------------------------------------
// brb_slot_mem
// Per-slot storage: the payload word and the outstanding reader count, one
// write port and one registered read port each.
// ----------------------------------------------------------------------------
module brb_slot_mem #(
    parameter int DEPTH  = 1024,
    parameter int DATA_W = 32,
    parameter int CNT_W  = 4
) (
    input  logic                     clk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_W-1:0]        rd_data,
    output logic [CNT_W-1:0]         rd_cnt,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic                     pay_we,
    input  logic [DATA_W-1:0]        pay_wr_data,
    input  logic                     cnt_we,
    input  logic [CNT_W-1:0]         cnt_wr_data
);

    logic [DATA_W-1:0] pay_mem [DEPTH];
    logic [CNT_W-1:0]  cnt_mem [DEPTH];

    // payload array
    always_ff @(posedge clk)
    begin
        if (pay_we)
        begin
            pay_mem[wr_addr] <= pay_wr_data;
        end
        if (rd_en)
        begin
            rd_data <= pay_mem[rd_addr];
        end
    end

    // outstanding count array
    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            cnt_mem[wr_addr] <= cnt_wr_data;
        end
        if (rd_en)
        begin
            rd_cnt <= cnt_mem[rd_addr];
        end
    end

endmodule

@@ hdl/broadcast_ring_buffer_multi_reader.sv @@
// ----------------------------------------------------------------------------
// broadcast_ring_buffer_multi_reader
// Single-writer ring buffer whose entries must be consumed by every active
// reader. Publish and consume requests each produce one result transaction.
// ----------------------------------------------------------------------------
// A request is captured together with a registered read of the slot memory,
// then executed as a read-modify-write that registers its result once the
// output is free. The block takes no new request until the current one has
// produced its result. Reset clears positions and the reader count to 2;
// slot counts need no clearing pass, since a wrap flag and the write
// position tell which slots have ever been written.
module broadcast_ring_buffer_multi_reader #(
    parameter int RING_DEPTH  = brb_pkg::RING_DEPTH_DEF,
    parameter int MAX_READERS = brb_pkg::MAX_READERS_DEF,
    parameter int DATA_WIDTH  = brb_pkg::DATA_WIDTH_DEF,
    localparam int PTR_W = $clog2(RING_DEPTH),
    localparam int IN_W  = ((brb_pkg::RID_W + DATA_WIDTH + 7) / 8) * 8,
    localparam int OUT_W = ((PTR_W + DATA_WIDTH + 7) / 8) * 8
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_wr_en,
    input  logic [brb_pkg::CFG_W-1:0] cfg_wr_data,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [IN_W-1:0]         s_tdata,  // reader_id, payload
    input  logic                    s_tuser,  // op
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [OUT_W-1:0]        m_tdata,  // slot_index, read_data
    output logic [3:0]              m_tuser   // accepted, full_res, empty_res, slot_released
);

    localparam int CNT_W = $clog2(MAX_READERS + 1);
    localparam logic [PTR_W-1:0] LAST_POS = PTR_W'(RING_DEPTH - 1);

    brb_pkg::state_t state_reg, state_next;

    logic [brb_pkg::CFG_W-1:0] active_readers_reg;
    logic [CNT_W-1:0]          eff_readers;

    logic [PTR_W-1:0] wr_pos_reg, wr_pos_next;
    logic             wrapped_reg, wrapped_next;
    logic [PTR_W-1:0] rd_pos_reg [MAX_READERS];
    logic [PTR_W-1:0] rd_pos_next [MAX_READERS];

    logic                     op_reg;
    logic [brb_pkg::RID_W-1:0] rid_reg;
    logic [DATA_WIDTH-1:0]    payload_reg;
    logic [PTR_W-1:0]         cur_rp_reg;
    logic                     written_reg;

    logic                     m_tvalid_reg, m_tvalid_next;
    brb_pkg::status_t         res_status_reg, res_status_next;
    logic [PTR_W-1:0]         res_slot_reg, res_slot_next;
    logic [DATA_WIDTH-1:0]    res_data_reg, res_data_next;

    logic [brb_pkg::RID_W-1:0] in_rid;
    logic [DATA_WIDTH-1:0]    in_payload;
    logic                     in_xact;
    logic [PTR_W-1:0]         sel_rp;

    logic [DATA_WIDTH-1:0] mem_rd_data;
    logic [CNT_W-1:0]      mem_rd_cnt;
    logic [PTR_W-1:0]      mem_wr_addr;
    logic                  pay_we;
    logic                  cnt_we;
    logic [CNT_W-1:0]      cnt_wr_data;

    logic             fire;
    logic [PTR_W-1:0] next_wp;
    logic [PTR_W-1:0] next_rp;
    logic             blocked;
    logic             rid_ok;
    logic [CNT_W-1:0] cnt_eff;
    logic             cons_empty;
    logic             pub_ok;
    logic             cons_ok;

    // input field unpacking
    assign in_rid     = s_tdata[brb_pkg::RID_W-1:0];
    assign in_payload = s_tdata[brb_pkg::RID_W +: DATA_WIDTH];
    assign s_tready   = (state_reg == brb_pkg::ST_IDLE);
    assign in_xact    = s_tvalid && s_tready;

    // output packing
    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = res_status_reg;
    assign m_tdata  = OUT_W'({res_data_reg, res_slot_reg});

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_readers_reg <= brb_pkg::ACTIVE_READERS_RST;
        end
        else if (cfg_wr_en)
        begin
            active_readers_reg <= cfg_wr_data;
        end
    end

    // clamp reader count to the number of reader positions
    always_comb
    begin
        if (int'(active_readers_reg) > MAX_READERS)
        begin
            eff_readers = CNT_W'(MAX_READERS);
        end
        else
        begin
            eff_readers = CNT_W'(active_readers_reg);
        end
    end

    // position of the requesting reader, used as memory read address
    always_comb
    begin
        sel_rp = '0;
        for (int i = 0; i < MAX_READERS; i++)
        begin
            if (int'(in_rid) == i)
            begin
                sel_rp = rd_pos_reg[i];
            end
        end
    end

    brb_slot_mem #(
        .DEPTH  (RING_DEPTH),
        .DATA_W (DATA_WIDTH),
        .CNT_W  (CNT_W)
    ) u_slot_mem (
        .clk         (clk),
        .rd_en       (in_xact),
        .rd_addr     (sel_rp),
        .rd_data     (mem_rd_data),
        .rd_cnt      (mem_rd_cnt),
        .wr_addr     (mem_wr_addr),
        .pay_we      (pay_we),
        .pay_wr_data (payload_reg),
        .cnt_we      (cnt_we),
        .cnt_wr_data (cnt_wr_data)
    );

    // request capture
    always_ff @(posedge clk)
    begin
        if (in_xact)
        begin
            op_reg      <= s_tuser;
            rid_reg     <= in_rid;
            payload_reg <= in_payload;
            cur_rp_reg  <= sel_rp;
            written_reg <= wrapped_reg || (sel_rp < wr_pos_reg);
        end
    end

    // full check, empty check and read-modify-write of the slot count
    always_comb
    begin
        fire    = (state_reg == brb_pkg::ST_EXEC) && (!m_tvalid_reg || m_tready);
        next_wp = (wr_pos_reg == LAST_POS) ? '0 : wr_pos_reg + 1'b1;
        next_rp = (cur_rp_reg == LAST_POS) ? '0 : cur_rp_reg + 1'b1;
        blocked = 1'b0;
        for (int i = 0; i < MAX_READERS; i++)
        begin
            if ((i < int'(eff_readers)) && (rd_pos_reg[i] == next_wp))
            begin
                blocked = 1'b1;
            end
        end
        rid_ok     = int'(rid_reg) < int'(eff_readers);
        cnt_eff    = written_reg ? mem_rd_cnt : '0;
        cons_empty = (cur_rp_reg == wr_pos_reg) || (cnt_eff == '0);
        pub_ok     = (op_reg == brb_pkg::OP_PUBLISH) && !blocked;
        cons_ok    = (op_reg == brb_pkg::OP_CONSUME) && rid_ok && !cons_empty;

        pay_we      = fire && pub_ok;
        cnt_we      = fire && (pub_ok || cons_ok);
        mem_wr_addr = (op_reg == brb_pkg::OP_PUBLISH) ? wr_pos_reg : cur_rp_reg;
        cnt_wr_data = (op_reg == brb_pkg::OP_PUBLISH) ? eff_readers : cnt_eff - 1'b1;
    end

    // position updates
    always_comb
    begin
        wr_pos_next  = wr_pos_reg;
        wrapped_next = wrapped_reg;
        if (fire && pub_ok)
        begin
            wr_pos_next = next_wp;
            if (wr_pos_reg == LAST_POS)
            begin
                wrapped_next = 1'b1;
            end
        end
        for (int i = 0; i < MAX_READERS; i++)
        begin
            rd_pos_next[i] = rd_pos_reg[i];
            if (fire && cons_ok && (int'(rid_reg) == i))
            begin
                rd_pos_next[i] = next_rp;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_pos_reg  <= '0;
            wrapped_reg <= 1'b0;
            for (int i = 0; i < MAX_READERS; i++)
            begin
                rd_pos_reg[i] <= '0;
            end
        end
        else
        begin
            wr_pos_reg  <= wr_pos_next;
            wrapped_reg <= wrapped_next;
            for (int i = 0; i < MAX_READERS; i++)
            begin
                rd_pos_reg[i] <= rd_pos_next[i];
            end
        end
    end

    // control state machine and result register
    always_comb
    begin
        state_next      = state_reg;
        m_tvalid_next   = m_tvalid_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_data_next   = res_data_reg;
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        unique case (state_reg)
            brb_pkg::ST_IDLE:
            begin
                if (in_xact)
                begin
                    state_next = brb_pkg::ST_EXEC;
                end
            end
            brb_pkg::ST_EXEC:
            begin
                if (fire)
                begin
                    state_next                    = brb_pkg::ST_IDLE;
                    m_tvalid_next                 = 1'b1;
                    res_status_next.accepted      = pub_ok || cons_ok;
                    res_status_next.full_res      = (op_reg == brb_pkg::OP_PUBLISH) && blocked;
                    res_status_next.empty_res     = (op_reg == brb_pkg::OP_CONSUME) && rid_ok
                                                    && cons_empty;
                    res_status_next.slot_released = cons_ok && (cnt_eff == CNT_W'(1));
                    res_slot_next                 = pub_ok  ? wr_pos_reg :
                                                    cons_ok ? cur_rp_reg : '0;
                    res_data_next                 = cons_ok ? mem_rd_data : '0;
                end
            end
            default:
            begin
                state_next = brb_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= brb_pkg::ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        res_data_reg   <= res_data_next;
    end

    // a captured request always moves to execution
    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        in_xact |=> (state_reg == brb_pkg::ST_EXEC))
        else $error("accepted request did not enter execution");

    // execution with a free output slot presents a result next cycle
    a_exec_result: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> (m_tvalid_reg && (state_reg == brb_pkg::ST_IDLE)))
        else $error("execution did not produce a result");

    // memory writes happen only while executing with the output free
    a_write_fire: assert property (@(posedge clk) disable iff (!rst_n)
        (pay_we || cnt_we) |-> fire)
        else $error("slot memory written outside execution");

    // a released slot implies an accepted consume with no refusal flags
    a_release_acc: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && res_status_reg.slot_released) |->
        (res_status_reg.accepted && !res_status_reg.full_res && !res_status_reg.empty_res))
        else $error("slot released without an accepted consume");

endmodule

@@ tb/ring_result_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ring_result_checker
// Watches the config port and both stream channels of the broadcast ring
// buffer. It keeps its own copy of the positions, slot words and owed counts,
// works out the result of every accepted request and compares each result
// transaction field by field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module ring_result_checker #(
    parameter int DEPTH   = brb_pkg::RING_DEPTH_DEF,
    parameter int READERS = brb_pkg::MAX_READERS_DEF,
    parameter int DATA_W  = brb_pkg::DATA_WIDTH_DEF,
    parameter int IN_W    = 40,
    parameter int OUT_W   = 48
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic [brb_pkg::CFG_W-1:0] cfg_wr_data,
    input  logic                      s_tvalid,
    input  logic                      s_tready,
    input  logic [IN_W-1:0]           s_tdata,   // reader_id, payload
    input  logic                      s_tuser,   // op
    input  logic                      m_tvalid,
    input  logic                      m_tready,
    input  logic [OUT_W-1:0]          m_tdata,   // slot_index, read_data
    input  logic [3:0]                m_tuser,   // accepted, full_res, empty_res, slot_released
    output int                        mismatches,
    output int                        outstanding
);

    localparam int PTR_W = $clog2(DEPTH);

    typedef struct packed {
        brb_pkg::status_t  flags;
        logic [PTR_W-1:0]  slot;
        logic [DATA_W-1:0] word;
    } ring_result_t;

    // mirror of the buffer state
    logic [brb_pkg::CFG_W-1:0] reader_setting;
    logic [PTR_W-1:0]          write_pos;
    logic [PTR_W-1:0]          read_pos [READERS];
    logic [DATA_W-1:0]         slot_word [DEPTH];
    logic [brb_pkg::CFG_W-1:0] slot_owed [DEPTH];

    ring_result_t     expected_results [$];
    ring_result_t     want;
    brb_pkg::status_t got_flags;

    // apply one request to the mirror and return its result
    function automatic ring_result_t apply_request(input logic op,
                                                   input logic [2:0] rid,
                                                   input logic [DATA_W-1:0] word);
        ring_result_t              res;
        logic [brb_pkg::CFG_W-1:0] live;
        logic [PTR_W-1:0]          nxt;
        logic [PTR_W-1:0]          rp;
        logic                      blocked;
        res = '0;
        if (reader_setting > READERS)
            live = READERS[brb_pkg::CFG_W-1:0];
        else
            live = reader_setting;
        if (op == brb_pkg::OP_PUBLISH)
        begin
            // refused while any active reader sits on the next slot
            nxt = write_pos + 1'b1;
            blocked = 1'b0;
            for (int i = 0; i < live; i++)
            begin
                if (read_pos[i] == nxt)
                    blocked = 1'b1;
            end
            if (blocked)
                res.flags.full_res = 1'b1;
            else
            begin
                slot_word[write_pos] = word;
                slot_owed[write_pos] = live;
                res.flags.accepted = 1'b1;
                res.slot = write_pos;
                write_pos = nxt;
            end
        end
        else if (rid < live)
        begin
            // unknown readers fall through with every flag low
            rp = read_pos[rid];
            if (rp == write_pos || slot_owed[rp] == '0)
                res.flags.empty_res = 1'b1;
            else
            begin
                res.flags.accepted = 1'b1;
                res.slot = rp;
                res.word = slot_word[rp];
                slot_owed[rp] = slot_owed[rp] - 1'b1;
                res.flags.slot_released = (slot_owed[rp] == '0);
                read_pos[rid] = rp + 1'b1;
            end
        end
        return res;
    endfunction

    task automatic check_field(input string name, input logic [DATA_W-1:0] exp_val,
                               input logic [DATA_W-1:0] act_val);
        if (act_val !== exp_val)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_val, act_val);
        end
    endtask

    // track config writes, predict on input, compare on output
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reader_setting = brb_pkg::ACTIVE_READERS_RST;
            write_pos = '0;
            for (int i = 0; i < READERS; i++)
                read_pos[i] = '0;
            for (int i = 0; i < DEPTH; i++)
            begin
                slot_word[i] = '0;
                slot_owed[i] = '0;
            end
            expected_results.delete();
            mismatches = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: result with nothing expected, actual tuser %h tdata %h",
                             $time, m_tuser, m_tdata);
                end
                else
                begin
                    want = expected_results.pop_front();
                    got_flags = m_tuser;
                    check_field("accepted", want.flags.accepted, got_flags.accepted);
                    check_field("full_res", want.flags.full_res, got_flags.full_res);
                    check_field("empty_res", want.flags.empty_res, got_flags.empty_res);
                    check_field("slot_released", want.flags.slot_released,
                                got_flags.slot_released);
                    check_field("slot_index", want.slot, m_tdata[PTR_W-1:0]);
                    check_field("read_data", want.word, m_tdata[PTR_W +: DATA_W]);
                end
            end
            if (cfg_wr_en)
                reader_setting = cfg_wr_data;
            if (s_tvalid && s_tready)
                expected_results.push_back(apply_request(s_tuser, s_tdata[2:0],
                                                         s_tdata[3 +: DATA_W]));
        end
        outstanding = expected_results.size();
    end

endmodule

@@ tb/tb_broadcast_ring_buffer_multi_reader.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_broadcast_ring_buffer_multi_reader
// Drives publish and consume requests into the broadcast ring buffer across
// several reader settings: a directed opening, then random phases that fill
// the ring to full, wrap it, strand readers and switch the reader count to
// its extremes. Both stream sides idle at random; a checker predicts and
// compares every result transaction.
// ----------------------------------------------------------------------------
module tb_broadcast_ring_buffer_multi_reader;

    localparam int PTR_W       = $clog2(brb_pkg::RING_DEPTH_DEF);
    localparam int DATA_W      = brb_pkg::DATA_WIDTH_DEF;
    localparam int IN_W        = ((brb_pkg::RID_W + DATA_W + 7) / 8) * 8;
    localparam int OUT_W       = ((PTR_W + DATA_W + 7) / 8) * 8;
    localparam int IDLE_PCT    = 17;
    localparam int CYCLE_LIMIT = 100000;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_wr_en;
    logic [brb_pkg::CFG_W-1:0] cfg_wr_data;
    logic                      s_tvalid;
    logic                      s_tready;
    logic [IN_W-1:0]           s_tdata;
    logic                      s_tuser;
    logic                      m_tvalid;
    logic                      m_tready;
    logic [OUT_W-1:0]          m_tdata;
    logic [3:0]                m_tuser;

    int mismatches;
    int outstanding;
    int cycle_count = 0;
    bit steady = 1'b0;

    broadcast_ring_buffer_multi_reader uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    ring_result_checker #(
        .IN_W  (IN_W),
        .OUT_W (OUT_W)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // result side back-pressure
    always @(negedge clk)
        m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_broadcast_ring_buffer_multi_reader: FAIL");
            $finish;
        end
    end

    // one request transaction, with random gaps before it
    task automatic push_request(input logic op, input logic [2:0] rid,
                                input logic [DATA_W-1:0] word);
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{(IN_W - brb_pkg::RID_W - DATA_W){1'b0}}, word, rid};
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    // change the reader count once every result is back
    task automatic write_readers(input logic [brb_pkg::CFG_W-1:0] value);
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0)
            @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // random requests under one reader setting
    task automatic run_phase(input logic [brb_pkg::CFG_W-1:0] value, input int publish_pct,
                             input int count, input bit calm);
        int         live;
        logic       op;
        logic [2:0] rid;
        write_readers(value);
        steady = calm;
        live = (value > brb_pkg::MAX_READERS_DEF) ? brb_pkg::MAX_READERS_DEF : value;
        repeat (count)
        begin
            op = ($urandom_range(99) < publish_pct) ? brb_pkg::OP_PUBLISH
                                                    : brb_pkg::OP_CONSUME;
            // mostly active readers, sometimes any id
            if (op == brb_pkg::OP_CONSUME && live > 0 && $urandom_range(99) < 85)
                rid = 3'($urandom_range(live - 1));
            else
                rid = 3'($urandom_range(7));
            push_request(op, rid, $urandom());
        end
        steady = 1'b0;
    endtask

    // stimulus and verdict
    initial
    begin
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = brb_pkg::OP_PUBLISH;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // empty ring at reset, readers beyond the default count
        push_request(brb_pkg::OP_CONSUME, 3'd0, 32'h0000_0000);
        push_request(brb_pkg::OP_CONSUME, 3'd2, 32'hFFFF_FFFF);
        push_request(brb_pkg::OP_CONSUME, 3'd7, 32'h0000_0000);

        // all eight readers, payload extremes, last reader drains to empty
        write_readers(4'd8);
        push_request(brb_pkg::OP_PUBLISH, 3'd7, 32'h0000_0000);
        push_request(brb_pkg::OP_PUBLISH, 3'd0, 32'hFFFF_FFFF);
        push_request(brb_pkg::OP_CONSUME, 3'd7, 32'hFFFF_FFFF);
        push_request(brb_pkg::OP_CONSUME, 3'd0, 32'h0000_0000);
        push_request(brb_pkg::OP_PUBLISH, 3'd5, 32'hA5A5_5A5A);
        push_request(brb_pkg::OP_CONSUME, 3'd7, 32'h5A5A_A5A5);
        push_request(brb_pkg::OP_CONSUME, 3'd7, 32'h0000_0000);
        push_request(brb_pkg::OP_CONSUME, 3'd7, 32'h0000_0000);

        // remaining readers of the first slot, the last one releases it
        for (int r = 1; r < 7; r++)
            push_request(brb_pkg::OP_CONSUME, r[2:0], 32'h0000_0000);

        // random phases: fill to full, wrap, stranded readers, zero readers
        run_phase(4'd8, 55, 150, 1'b0);
        run_phase(4'd3, 55, 120, 1'b1);
        run_phase(4'd1, 99, 980, 1'b0);
        run_phase(4'd1, 50, 100, 1'b1);
        run_phase(4'd15, 40, 80, 1'b0);
        run_phase(4'd0, 50, 30, 1'b0);
        run_phase(4'd2, 45, 60, 1'b0);

        // drain
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);

        if (mismatches == 0)
            $display("tb_broadcast_ring_buffer_multi_reader: PASS");
        else
            $display("tb_broadcast_ring_buffer_multi_reader: FAIL");
        $finish;
    end

endmodule
